// ===== hdl/wpd_pkg.sv =====
`default_nettype none
package wpd_pkg;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_HEADER  = 3'd1;
  localparam logic [2:0] ST_TRUNCATED   = 3'd2;
  localparam logic [2:0] ST_SHORT_FMT   = 3'd3;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
  localparam logic [15:0] PCM_CODE = 16'd1;
  localparam logic [15:0] PCM_BITS = 16'd16;

  localparam logic [3:0] FB_CODE_LO = 4'd0;
  localparam logic [3:0] FB_CODE_HI = 4'd1;
  localparam logic [3:0] FB_CH_LO   = 4'd2;
  localparam logic [3:0] FB_CH_HI   = 4'd3;
  localparam logic [3:0] FB_RATE_0  = 4'd4;
  localparam logic [3:0] FB_RATE_1  = 4'd5;
  localparam logic [3:0] FB_RATE_2  = 4'd6;
  localparam logic [3:0] FB_RATE_3  = 4'd7;
  localparam logic [3:0] FB_BITS_LO = 4'd14;
  localparam logic [3:0] FB_BITS_HI = 4'd15;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } wpd_in_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] sample;
    logic [2:0]         status;
    logic [31:0]        rate_hz;
    logic [15:0]        channel_count;
    logic               last;
  } wpd_out_t;

  typedef struct packed {
    logic        clr;
    logic        fmt_wr;
    logic [3:0]  fmt_idx;
    logic        data_start;
    logic [31:0] chunk_len;
    logic        data_lo;
    logic        data_hi;
    logic [7:0]  data_byte;
    logic        ld_sample;
    logic        ld_status;
    logic [2:0]  status;
  } wpd_cmd_t;

  typedef struct packed {
    logic fmt_usable;
    logic data_len_nz;
    logic frame_fire;
    logic div_done;
  } wpd_sts_t;

endpackage
`default_nettype wire

// ===== hdl/wav_pcm16_downmix_parser.sv =====
// Channel   Direction  Handshake               Payload
// byte      in         byte_valid/byte_stall   wpd_in_t  (file byte, end-of-file mark)
// res       out        res_valid/res_stall     wpd_out_t (sample or status)
//
// One file byte is taken per cycle while no frame is being averaged and no result is waiting to load.
// A byte that completes a frame stalls the input while the iterative divider runs,
// while the control sees it finish and while the sample is loaded.
// A byte marked end-of-file stalls the input while the status is loaded as well,
// then the parser returns to its reset state. Reset is synchronous, active high.
// A stalled result waits in the output register; a new result waits behind it.
`default_nettype none
module wav_pcm16_downmix_parser
  import wpd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     byte_valid,
  output logic     byte_stall,
  input  wpd_in_t  byte_data,
  output logic     res_valid,
  input  logic     res_stall,
  output wpd_out_t res_data
);

  wpd_cmd_t cmd;
  wpd_sts_t sts;

  wpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (byte_valid),
    .in_stall  (byte_stall),
    .in_data   (byte_data),
    .out_valid (res_valid),
    .out_stall (res_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  wpd_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (res_data)
  );

endmodule
`default_nettype wire

// ===== hdl/wpd_div.sv =====
`default_nettype none
module wpd_div
  import wpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic [15:0]        divisor,
  output logic               done,
  output logic signed [15:0] quotient
);

  logic        busy;
  logic [4:0]  cnt;
  logic        neg;
  logic [31:0] quo;
  logic [15:0] rem;
  logic [16:0] trial;
  logic [16:0] diff;

  assign trial = {rem, quo[31]};
  assign diff = trial - {1'b0, divisor};
  assign quotient = neg ? -signed'(quo[15:0]) : signed'(quo[15:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[31];
      quo <= dividend[31] ? -dividend : dividend;
      rem <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, divisor}) begin
        rem <= diff[15:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= trial[15:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/wpd_dp.sv =====
`default_nettype none
module wpd_dp
  import wpd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  wpd_cmd_t cmd,
  output wpd_sts_t sts,
  output wpd_out_t out_data
);

  logic [15:0]        fmt_code;
  logic [15:0]        fmt_channels;
  logic [31:0]        fmt_rate;
  logic [15:0]        fmt_bits;
  logic [31:0]        data_length;
  logic [7:0]         low_byte;
  logic [15:0]        channel_index;
  logic signed [31:0] frame_sum;
  logic [15:0]        idx_inc;
  logic signed [15:0] smp;
  logic signed [31:0] sum_next;
  logic               div_done;
  logic signed [15:0] div_q;

  assign idx_inc = channel_index + 16'd1;
  assign smp = {cmd.data_byte, low_byte};
  assign sum_next = frame_sum + {{16{smp[15]}}, smp};

  assign sts.fmt_usable = (fmt_code == PCM_CODE) && (fmt_channels != '0) &&
                          (fmt_rate != '0) && (fmt_bits == PCM_BITS);
  assign sts.data_len_nz = data_length != '0;
  assign sts.frame_fire = cmd.data_hi && (idx_inc >= fmt_channels);
  assign sts.div_done = div_done;

  wpd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (sts.frame_fire),
    .dividend (sum_next),
    .divisor  (fmt_channels),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      fmt_code <= '0;
      fmt_channels <= '0;
      fmt_rate <= '0;
      fmt_bits <= '0;
      data_length <= '0;
      low_byte <= '0;
      channel_index <= '0;
      frame_sum <= '0;
    end else begin
      if (cmd.fmt_wr) begin
        case (cmd.fmt_idx)
          FB_CODE_LO: fmt_code[7:0] <= cmd.data_byte;
          FB_CODE_HI: fmt_code[15:8] <= cmd.data_byte;
          FB_CH_LO:   fmt_channels[7:0] <= cmd.data_byte;
          FB_CH_HI:   fmt_channels[15:8] <= cmd.data_byte;
          FB_RATE_0:  fmt_rate[7:0] <= cmd.data_byte;
          FB_RATE_1:  fmt_rate[15:8] <= cmd.data_byte;
          FB_RATE_2:  fmt_rate[23:16] <= cmd.data_byte;
          FB_RATE_3:  fmt_rate[31:24] <= cmd.data_byte;
          FB_BITS_LO: fmt_bits[7:0] <= cmd.data_byte;
          FB_BITS_HI: fmt_bits[15:8] <= cmd.data_byte;
          default: ;
        endcase
      end
      if (cmd.data_start) begin
        data_length <= cmd.chunk_len;
        channel_index <= '0;
        frame_sum <= '0;
      end
      if (cmd.data_lo) begin
        low_byte <= cmd.data_byte;
      end
      if (cmd.data_hi) begin
        if (sts.frame_fire) begin
          channel_index <= '0;
          frame_sum <= '0;
        end else begin
          channel_index <= idx_inc;
          frame_sum <= sum_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_sample) begin
      out_data.kind <= 1'b0;
      out_data.sample <= div_q;
      out_data.status <= ST_OK;
      out_data.rate_hz <= fmt_rate;
      out_data.channel_count <= fmt_channels;
      out_data.last <= 1'b0;
    end else if (cmd.ld_status) begin
      out_data.kind <= 1'b1;
      out_data.sample <= '0;
      out_data.status <= cmd.status;
      out_data.rate_hz <= fmt_rate;
      out_data.channel_count <= fmt_channels;
      out_data.last <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/wpd_ctrl.sv =====
`default_nettype none
module wpd_ctrl
  import wpd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  wpd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output wpd_cmd_t cmd,
  input  wpd_sts_t sts
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_CHUNK  = 3'd1;
  localparam logic [2:0] PH_FMT    = 3'd2;
  localparam logic [2:0] PH_SHORT  = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;
  localparam logic [2:0] PH_DATA   = 3'd5;
  localparam logic [2:0] PH_PAD    = 3'd6;
  localparam logic [2:0] PH_HALT   = 3'd7;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIV   = 2'd1;
  localparam logic [1:0] S_SLOAD = 2'd2;
  localparam logic [1:0] S_ELOAD = 2'd3;

  logic [1:0]  state, state_next;
  logic [2:0]  phase, phase_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [31:0] chunk_tag, chunk_tag_next;
  logic [31:0] chunk_remaining, chunk_remaining_next;
  logic        pad_pending, pad_pending_next;
  logic [2:0]  error_code, error_code_next;
  logic        eof_pend, eof_pend_next;
  logic        oval, oval_next;

  logic        accept;
  logic        out_free;
  logic [7:0]  b;
  logic [31:0] tag_sh;
  logic [31:0] rem_sh;
  logic [31:0] rem_dec;
  logic [2:0]  eof_status;

  assign accept = in_valid && (state == S_IDLE);
  assign in_stall = state != S_IDLE;
  assign out_valid = oval;
  assign out_free = !oval || !out_stall;
  assign b = in_data.in_byte;
  assign tag_sh = {b, chunk_tag[31:8]};
  assign rem_sh = {b, chunk_remaining[31:8]};
  assign rem_dec = chunk_remaining - 32'd1;

  always_comb begin
    if (error_code != ST_OK) begin
      eof_status = error_code;
    end else if (phase == PH_HEADER) begin
      eof_status = ST_BAD_HEADER;
    end else if (phase == PH_FMT || phase == PH_SHORT || phase == PH_SKIP ||
                 phase == PH_DATA) begin
      eof_status = ST_TRUNCATED;
    end else if (!sts.fmt_usable || !sts.data_len_nz) begin
      eof_status = ST_UNSUPPORTED;
    end else begin
      eof_status = ST_OK;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    byte_count_next = byte_count;
    chunk_tag_next = chunk_tag;
    chunk_remaining_next = chunk_remaining;
    pad_pending_next = pad_pending;
    error_code_next = error_code;
    eof_pend_next = eof_pend;
    cmd = '0;
    cmd.data_byte = b;
    cmd.fmt_idx = byte_count;
    cmd.chunk_len = rem_sh;

    if (accept) begin
      case (phase)
        PH_HEADER: begin
          chunk_tag_next = tag_sh;
          if (byte_count == 4'd3 && tag_sh != TAG_RIFF) begin
            error_code_next = ST_BAD_HEADER;
            phase_next = PH_HALT;
          end else if (byte_count == 4'd11) begin
            if (tag_sh != TAG_WAVE) begin
              error_code_next = ST_BAD_HEADER;
              phase_next = PH_HALT;
            end else begin
              phase_next = PH_CHUNK;
              byte_count_next = '0;
              chunk_tag_next = '0;
              chunk_remaining_next = '0;
            end
          end else begin
            byte_count_next = byte_count + 4'd1;
          end
        end
        PH_CHUNK: begin
          if (byte_count < 4'd4) begin
            chunk_tag_next = tag_sh;
          end else begin
            chunk_remaining_next = rem_sh;
          end
          if (byte_count == 4'd7) begin
            pad_pending_next = rem_sh[0];
            byte_count_next = '0;
            if (chunk_tag == TAG_FMT) begin
              phase_next = (rem_sh < FMT_MIN_SIZE) ? PH_SHORT : PH_FMT;
            end else if (chunk_tag == TAG_DATA && sts.fmt_usable) begin
              cmd.data_start = 1'b1;
              phase_next = PH_DATA;
            end else begin
              phase_next = PH_SKIP;
            end
            if (rem_sh == '0) begin
              if (chunk_tag == TAG_FMT) begin
                error_code_next = ST_SHORT_FMT;
                phase_next = PH_HALT;
              end else begin
                phase_next = PH_CHUNK;
                chunk_tag_next = '0;
                chunk_remaining_next = '0;
              end
            end
          end else begin
            byte_count_next = byte_count + 4'd1;
          end
        end
        PH_FMT, PH_SHORT, PH_SKIP, PH_DATA: begin
          chunk_remaining_next = rem_dec;
          if (phase == PH_FMT) begin
            cmd.fmt_wr = 1'b1;
            if (byte_count == 4'd15) begin
              phase_next = PH_SKIP;
            end else begin
              byte_count_next = byte_count + 4'd1;
            end
          end else if (phase == PH_DATA) begin
            if (!byte_count[0]) begin
              cmd.data_lo = 1'b1;
              byte_count_next = 4'd1;
            end else begin
              cmd.data_hi = 1'b1;
              byte_count_next = '0;
            end
          end
          if (rem_dec == '0) begin
            if (phase == PH_SHORT) begin
              error_code_next = ST_SHORT_FMT;
              phase_next = PH_HALT;
            end else if (pad_pending) begin
              phase_next = PH_PAD;
            end else begin
              phase_next = PH_CHUNK;
              byte_count_next = '0;
              chunk_tag_next = '0;
              chunk_remaining_next = '0;
            end
          end
        end
        PH_PAD: begin
          phase_next = PH_CHUNK;
          byte_count_next = '0;
          chunk_tag_next = '0;
          chunk_remaining_next = '0;
        end
        default: ;
      endcase
    end

    case (state)
      S_IDLE: begin
        if (accept) begin
          eof_pend_next = in_data.end_of_file;
          if (sts.frame_fire) begin
            state_next = S_DIV;
          end else if (in_data.end_of_file) begin
            state_next = S_ELOAD;
          end
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_SLOAD;
        end
      end
      S_SLOAD: begin
        if (out_free) begin
          cmd.ld_sample = 1'b1;
          state_next = eof_pend ? S_ELOAD : S_IDLE;
        end
      end
      S_ELOAD: begin
        if (out_free) begin
          cmd.ld_status = 1'b1;
          cmd.status = eof_status;
          cmd.clr = 1'b1;
          state_next = S_IDLE;
          eof_pend_next = 1'b0;
          phase_next = PH_HEADER;
          byte_count_next = '0;
          chunk_tag_next = '0;
          chunk_remaining_next = '0;
          pad_pending_next = 1'b0;
          error_code_next = ST_OK;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (cmd.ld_sample || cmd.ld_status) begin
      oval_next = 1'b1;
    end else if (!out_stall) begin
      oval_next = 1'b0;
    end else begin
      oval_next = oval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_HEADER;
      byte_count <= '0;
      chunk_tag <= '0;
      chunk_remaining <= '0;
      pad_pending <= 1'b0;
      error_code <= ST_OK;
      eof_pend <= 1'b0;
      oval <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      byte_count <= byte_count_next;
      chunk_tag <= chunk_tag_next;
      chunk_remaining <= chunk_remaining_next;
      pad_pending <= pad_pending_next;
      error_code <= error_code_next;
      eof_pend <= eof_pend_next;
      oval <= oval_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/wpd_chk.sv =====
`default_nettype none
module wpd_chk
  import wpd_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     byte_valid,
  input logic     byte_stall,
  input wpd_in_t  byte_data,
  input logic     res_valid,
  input logic     res_stall,
  input wpd_out_t res_data
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

  a_eof_stall: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_stall && byte_data.end_of_file |=> byte_stall)
    else $error("input taken before end-of-file status was issued");

  a_sample_fmt: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.kind |-> res_data.channel_count != '0 && !res_data.last)
    else $error("sample result without a usable format");

  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid && !byte_stall)
    else $error("outputs not idle after reset");

endmodule

bind wav_pcm16_downmix_parser wpd_chk u_chk (.*);
`default_nettype wire

// ===== tb/tb_wav_pcm16_downmix_parser.sv =====
`default_nettype none
module tb_wav_pcm16_downmix_parser;
  import wpd_pkg::*;

  localparam int TOTAL_BYTES = 1450;
  localparam int STALL_LIMIT = 4000;

  typedef enum logic [3:0] {
    P_HEADER, P_CHUNK, P_FMT, P_SHORT, P_SKIP, P_DATA, P_PAD, P_HALT
  } parse_phase_e;

  typedef struct {
    logic [7:0] b;
    logic       eof;
    logic       typed;
    logic [2:0] st;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     byte_valid = 1'b0;
  logic     byte_stall;
  wpd_in_t  byte_data = '0;
  logic     res_valid;
  logic     res_stall = 1'b0;
  wpd_out_t res_data;

  wav_pcm16_downmix_parser i_dut (
    .clk(clk), .rst(rst),
    .byte_valid(byte_valid), .byte_stall(byte_stall), .byte_data(byte_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser mirror state.
  parse_phase_e ph;
  logic [3:0]   bcnt;
  logic [31:0]  tag;
  logic [32:0]  remain;
  logic         pad;
  logic [15:0]  f_code, f_ch, f_bits;
  logic [31:0]  f_rate, data_len;
  logic [7:0]   low_b;
  logic [15:0]  ch_idx;
  int           fsum;
  logic [2:0]   err;

  wpd_out_t expected_results[$];
  logic [7:0] file_q[$];
  int   errors = 0;
  int   bytes_sent = 0;
  int   n_files = 0;
  int   n_samples = 0;
  int   n_status = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   quiet = 0;

  function automatic void clear_parser();
    ph = P_HEADER; bcnt = '0; tag = '0; remain = '0; pad = 1'b0;
    f_code = '0; f_ch = '0; f_rate = '0; f_bits = '0; data_len = '0;
    low_b = '0; ch_idx = '0; fsum = 0; err = ST_OK;
  endfunction

  function automatic logic fmt_ok();
    return f_code == PCM_CODE && f_ch != 0 && f_rate != 0 && f_bits == PCM_BITS;
  endfunction

  function automatic void halt_with(logic [2:0] code);
    err = code;
    ph = P_HALT;
  endfunction

  function automatic void next_chunk();
    ph = P_CHUNK; bcnt = '0; tag = '0; remain = '0;
  endfunction

  function automatic void end_payload();
    if (ph == P_SHORT) halt_with(ST_SHORT_FMT);
    else if (pad) ph = P_PAD;
    else next_chunk();
  endfunction

  function automatic void emit(logic k, logic [15:0] s, logic [2:0] st);
    wpd_out_t r;
    r.kind = k; r.sample = s; r.status = st;
    r.rate_hz = f_rate; r.channel_count = f_ch; r.last = k;
    expected_results.push_back(r);
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic eof);
    logic [15:0] raw;
    logic [31:0] sz;
    logic [2:0]  st;
    int          q;
    case (ph)
      P_HEADER: begin
        tag = {b, tag[31:8]};
        if (bcnt == 3 && tag != TAG_RIFF) halt_with(ST_BAD_HEADER);
        else if (bcnt == 11) begin
          if (tag != TAG_WAVE) halt_with(ST_BAD_HEADER);
          else next_chunk();
        end else bcnt++;
      end
      P_CHUNK: begin
        if (bcnt < 4) tag = {b, tag[31:8]};
        else remain = {1'b0, b, remain[31:8]};
        if (bcnt == 7) begin
          sz = remain[31:0];
          pad = sz[0];
          bcnt = '0;
          if (tag == TAG_FMT) ph = (sz < FMT_MIN_SIZE) ? P_SHORT : P_FMT;
          else if (tag == TAG_DATA && fmt_ok()) begin
            data_len = sz; ph = P_DATA; ch_idx = '0; fsum = 0;
          end else ph = P_SKIP;
          if (remain == 0) end_payload();
        end else bcnt++;
      end
      P_FMT, P_SHORT, P_SKIP, P_DATA: begin
        remain = remain - 1;
        if (ph == P_FMT) begin
          case (bcnt)
            FB_CODE_LO: f_code[7:0] = b;
            FB_CODE_HI: f_code[15:8] = b;
            FB_CH_LO:   f_ch[7:0] = b;
            FB_CH_HI:   f_ch[15:8] = b;
            FB_RATE_0:  f_rate[7:0] = b;
            FB_RATE_1:  f_rate[15:8] = b;
            FB_RATE_2:  f_rate[23:16] = b;
            FB_RATE_3:  f_rate[31:24] = b;
            FB_BITS_LO: f_bits[7:0] = b;
            FB_BITS_HI: f_bits[15:8] = b;
            default: ;
          endcase
          if (bcnt == 15) ph = P_SKIP;
          else bcnt++;
        end else if (ph == P_DATA) begin
          if (!bcnt[0]) begin
            low_b = b; bcnt = 4'd1;
          end else begin
            raw = {b, low_b};
            bcnt = '0;
            fsum += int'($signed(raw));
            ch_idx++;
            if (ch_idx >= f_ch) begin
              q = fsum / int'({16'b0, f_ch});
              emit(1'b0, q[15:0], ST_OK);
              ch_idx = '0; fsum = 0;
            end
          end
        end
        if (remain == 0) end_payload();
      end
      P_PAD: next_chunk();
      default: ;
    endcase
    if (eof) begin
      if (err != ST_OK) st = err;
      else if (ph == P_HEADER) st = ST_BAD_HEADER;
      else if (ph inside {P_FMT, P_SHORT, P_SKIP, P_DATA}) st = ST_TRUNCATED;
      else if (!fmt_ok() || data_len == 0) st = ST_UNSUPPORTED;
      else st = ST_OK;
      emit(1'b1, 16'd0, st);
      clear_parser();
    end
  endfunction

  task automatic send_request(logic [7:0] b, logic eof);
    while ($urandom_range(99) < idle_pct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_data <= '{in_byte: b, end_of_file: eof};
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    parse_byte(b, eof);
    bytes_sent++;
    @(negedge clk);
  endtask

  function automatic void put16(logic [15:0] v);
    file_q.push_back(v[7:0]); file_q.push_back(v[15:8]);
  endfunction

  function automatic void put32(logic [31:0] v);
    put16(v[15:0]); put16(v[31:16]);
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void make_file();
    int nch, kind, sz, frames, cut;
    logic [15:0] chans;
    file_q.delete();
    chans = 16'd2;
    put32(TAG_RIFF); put32($urandom); put32(TAG_WAVE);
    if ($urandom_range(11) == 0) file_q[$urandom_range(11)] = 8'($urandom);
    nch = $urandom_range(1, 4);
    for (int c = 0; c < nch; c++) begin
      if (c == 0 && $urandom_range(9) < 7) kind = 0;
      else if (c == 1 && $urandom_range(9) < 6) kind = 4;
      else kind = $urandom_range(5);
      case (kind)
        0, 1: begin
          sz = ($urandom_range(3) == 0) ? 16 + $urandom_range(3) : 16;
          chans = 16'($urandom_range(1, 4));
          put32(TAG_FMT); put32(sz);
          put16(PCM_CODE); put16(chans); put32($urandom_range(1, 96000) + 32'h0);
          put32($urandom); put16(16'($urandom)); put16(PCM_BITS);
          if (kind == 1) begin
            case ($urandom_range(3))
              0: file_q[file_q.size() - 16] = 8'($urandom_range(2, 255));
              1: begin
                file_q[file_q.size() - 14] = 8'h00;
                file_q[file_q.size() - 13] = 8'h00;
              end
              2: begin
                for (int k = 12; k >= 9; k--) file_q[file_q.size() - k] = 8'h00;
              end
              default: file_q[file_q.size() - 2] = 8'($urandom_range(17, 255));
            endcase
          end
          for (int k = 16; k < sz; k++) file_q.push_back(8'($urandom));
          if (sz[0]) file_q.push_back(8'($urandom));
        end
        2: begin
          sz = $urandom_range(15);
          put32(TAG_FMT); put32(sz);
          for (int k = 0; k < sz; k++) file_q.push_back(8'($urandom));
          if (sz[0]) file_q.push_back(8'($urandom));
        end
        3: begin
          sz = ($urandom_range(7) == 0) ? 32'hFFFF_FFF0 : $urandom_range(7);
          put32($urandom); put32(sz);
          for (int k = 0; k < sz && k < 8; k++) file_q.push_back(8'($urandom));
          if (sz[0] && sz < 8) file_q.push_back(8'($urandom));
        end
        default: begin
          frames = $urandom_range(0, 4);
          sz = frames * 2 * chans + (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
          put32(TAG_DATA); put32(sz);
          for (int k = 0; k < sz / 2; k++) put16(pick_sample());
          if (sz[0]) begin
            file_q.push_back(8'($urandom)); file_q.push_back(8'($urandom));
          end
        end
      endcase
    end
    if ($urandom_range(4) == 0) begin
      cut = $urandom_range(1, file_q.size());
      while (file_q.size() > cut) void'(file_q.pop_back());
    end
  endfunction

  always @(negedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    wpd_out_t e;
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, res_data);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (res_data.kind != e.kind || res_data.sample != e.sample ||
            res_data.status != e.status || res_data.rate_hz != e.rate_hz ||
            res_data.channel_count != e.channel_count || res_data.last != e.last) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, res_data);
          errors++;
        end
        if (e.kind) n_status++;
        else n_samples++;
      end
    end
  end

  always @(posedge clk) begin
    if ((byte_valid && !byte_stall) || (res_valid && !res_stall) || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
      $display("tb_wav_pcm16_downmix_parser NOT OK");
      $finish;
    end
  end

  dir_row_t dir_tbl[18] = '{
    '{8'h52, 1'b1, 1'b1, ST_BAD_HEADER},
    '{8'h52, 1'b0, 1'b0, ST_OK}, '{8'h49, 1'b0, 1'b0, ST_OK},
    '{8'h46, 1'b0, 1'b0, ST_OK}, '{8'h58, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b1, 1'b1, ST_BAD_HEADER},
    '{8'h52, 1'b0, 1'b0, ST_OK}, '{8'h49, 1'b0, 1'b0, ST_OK},
    '{8'h46, 1'b0, 1'b0, ST_OK}, '{8'h46, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h57, 1'b0, 1'b0, ST_OK}, '{8'h41, 1'b0, 1'b0, ST_OK},
    '{8'h56, 1'b0, 1'b0, ST_OK}, '{8'h45, 1'b1, 1'b1, ST_UNSUPPORTED}
  };

  initial begin
    wpd_out_t r;
    clear_parser();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (dir_tbl[i]) begin
      send_request(dir_tbl[i].b, dir_tbl[i].eof);
      if (dir_tbl[i].typed) begin
        r = expected_results.pop_back();
        r.status = dir_tbl[i].st;
        expected_results.push_back(r);
      end
    end
    byte_valid <= 1'b0;
    for (int p = 0; p < 4; p++) begin
      while (expected_results.size() != 0) @(negedge clk);
      repeat (40) @(negedge clk);
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 74; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      while (bytes_sent < (p + 1) * TOTAL_BYTES / 4) begin
        make_file();
        n_files++;
        foreach (file_q[k]) send_request(file_q[k], k == file_q.size() - 1);
      end
      byte_valid <= 1'b0;
    end
    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d bytes in %0d random files plus directed headers.", bytes_sent, n_files);
    $display("Checked %0d downmixed samples and %0d status results.", n_samples, n_status);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb_wav_pcm16_downmix_parser OK");
    end else begin
      $display("tb_wav_pcm16_downmix_parser NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
hdl/wpd_pkg.sv
hdl/wpd_div.sv
hdl/wpd_dp.sv
hdl/wpd_ctrl.sv
hdl/wav_pcm16_downmix_parser.sv
hdl/wpd_chk.sv
tb/tb_wav_pcm16_downmix_parser.sv
